[src/byte_histogram_min_max_assert.svh]
// Assertion macros used by the histogram top module.
`ifndef BYTE_HISTOGRAM_MIN_MAX_ASSERT_SVH
`define BYTE_HISTOGRAM_MIN_MAX_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge of CLK_ while RST_N_ is high.
`define BHMM_ASSERT(LABEL_, CLK_, RST_N_, PROP_) \
	LABEL_: assert property (@(posedge CLK_) disable iff (!RST_N_) PROP_) \
		else $error("byte histogram: assertion failed");

// The expression must never be true at a rising edge of CLK_ while RST_N_ is high.
`define BHMM_NEVER(LABEL_, CLK_, RST_N_, EXPR_) \
	LABEL_: assert property (@(posedge CLK_) disable iff (!RST_N_) !(EXPR_)) \
		else $error("byte histogram: forbidden condition seen");

`else

`define BHMM_ASSERT(LABEL_, CLK_, RST_N_, PROP_)
`define BHMM_NEVER(LABEL_, CLK_, RST_N_, EXPR_)

`endif

`endif

[src/bhmm_pkg.sv]
package bhmm_pkg;

	localparam int COUNT_BITS = 32;
	localparam int NUM_BINS   = 256;
	localparam int SYM_BITS   = $clog2(NUM_BINS);
	localparam int FIELD_BITS = 32;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [SYM_BITS-1:0]   sym_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	typedef enum logic [1:0] {
		CMD_COUNT  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_REPORT = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	localparam logic KIND_BIN     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One write into the bin store.
	typedef struct packed {
		logic   en;
		sym_t   addr;
		count_t data;
	} wr_req_t;

	// Low FIELD_BITS bits of a counter, zero extended when the counter is narrower.
	function automatic field_t to_field(count_t v);
		logic [COUNT_BITS+FIELD_BITS-1:0] wide;
		wide = {{FIELD_BITS{1'b0}}, v};
		return wide[FIELD_BITS-1:0];
	endfunction

endpackage

[src/bhmm_if.sv]
interface bhmm_item_if import bhmm_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	sym_t       symbol;

	modport source (output valid, output cmd, output symbol, input ready);
	modport sink (input valid, input cmd, input symbol, output ready);
endinterface

interface bhmm_result_if import bhmm_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   result_kind;
	field_t bin_count;
	field_t min_count;
	field_t max_count;

	modport source (
		output valid, output result_kind, output bin_count,
		output min_count, output max_count, input ready
	);
	modport sink (
		input valid, input result_kind, input bin_count,
		input min_count, input max_count, output ready
	);
endinterface

[src/bhmm_bins.sv]
module bhmm_bins import bhmm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    rd_en,
	input  sym_t    rd_addr,
	output count_t  rd_data,
	input  wr_req_t wr,
	input  logic    clear_all
);

	count_t mem [NUM_BINS];
	count_t rd_raw_q;
	logic   hit_q;
	logic [NUM_BINS-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// A bin that was not written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
			if (clear_all) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	assign rd_data = hit_q ? rd_raw_q : '0;

endmodule

[src/byte_histogram_min_max.sv]
// Byte histogram with 256 saturating bin counters and a min/max summary.
// The item channel carries cmd and symbol: count a byte, read one bin, report
// the least and greatest count, or clear every bin. Transfers on the result
// channel happen only for reads and reports.
// Count and read commands are taken one per cycle, except during a report or
// while a read waits on a full result register. Each goes through a single
// read-modify-write stage on the bin memory; a count that hits the bin written
// in the cycle before is served from a forwarding register. A bin read result
// waits in that stage until the result register is free. A report walks the
// memory one bin per cycle; the item channel is held off until the summary has
// entered the result register, which may wait for that register to empty.
// Clear takes effect in the cycle of its transfer by dropping the valid bit of
// every bin; the next item already sees zeros.
// Reset clears the valid bits at once, so no sweep over the memory follows it.
// The result sits in one output register. While the receiver stalls, counts
// keep flowing; a read or report waits behind a result that has not moved.
`include "byte_histogram_min_max_assert.svh"

module byte_histogram_min_max import bhmm_pkg::*; (
	input logic clk,
	input logic arst_n,
	bhmm_item_if.sink     item,
	bhmm_result_if.source result
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_SCAN,
		ST_REPORT
	} state_t;

	localparam sym_t SCAN_LAST = sym_t'(NUM_BINS - 1);

	state_t  state_q;
	sym_t    scan_idx_q;
	logic    scan_vld_s1;
	logic    scan_first_s1;
	count_t  min_q;
	count_t  max_q;

	logic    vld_s1;
	cmd_t    cmd_s1;
	sym_t    sym_s1;
	wr_req_t fwd_q;

	logic    out_vld_q;
	logic    out_kind_q;
	field_t  out_bin_q;
	field_t  out_min_q;
	field_t  out_max_q;

	cmd_t    item_cmd;
	logic    advance;
	logic    acc;
	logic    out_free;
	logic    rd_en;
	sym_t    rd_addr;
	count_t  rd_data;
	logic    clear_all;
	logic    fwd_hit;
	count_t  cur;
	wr_req_t wr;
	logic    rd_done;
	logic    sum_done;

	assign item_cmd = cmd_t'(item.cmd);
	assign out_free = !out_vld_q || result.ready;

	// Only a bin read waiting on a full result register stops the pipeline.
	assign advance    = !(vld_s1 && cmd_s1 == CMD_READ && !out_free);
	assign item.ready = (state_q == ST_RUN) && advance;
	assign acc        = item.valid && item.ready;
	assign clear_all  = acc && item_cmd == CMD_CLEAR;

	assign rd_done  = vld_s1 && cmd_s1 == CMD_READ && advance;
	assign sum_done = (state_q == ST_REPORT) && !scan_vld_s1 && out_free;

	assign rd_en   = advance;
	assign rd_addr = (state_q == ST_SCAN) ? scan_idx_q : item.symbol;

	assign fwd_hit = fwd_q.en && fwd_q.addr == sym_s1;
	assign cur     = fwd_hit ? fwd_q.data : rd_data;

	always_comb begin
		wr.en   = vld_s1 && cmd_s1 == CMD_COUNT;
		wr.addr = sym_s1;
		wr.data = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + count_t'(1);
	end

	bhmm_bins u_bins (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr        (wr),
		.clear_all (clear_all)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			vld_s1      <= 1'b0;
			fwd_q       <= '0;
			out_vld_q   <= 1'b0;
			out_kind_q  <= KIND_BIN;
			out_bin_q   <= '0;
			out_min_q   <= '0;
			out_max_q   <= '0;
		end else begin
			if (advance) begin
				vld_s1 <= acc && (item_cmd == CMD_COUNT || item_cmd == CMD_READ);
				fwd_q  <= '{en: wr.en && !clear_all, addr: wr.addr, data: wr.data};
			end

			if (rd_done) begin
				out_vld_q  <= 1'b1;
				out_kind_q <= KIND_BIN;
				out_bin_q  <= to_field(cur);
				out_min_q  <= '0;
				out_max_q  <= '0;
			end else if (sum_done) begin
				out_vld_q  <= 1'b1;
				out_kind_q <= KIND_SUMMARY;
				out_bin_q  <= '0;
				out_min_q  <= to_field(min_q);
				out_max_q  <= to_field(max_q);
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			scan_vld_s1 <= (state_q == ST_SCAN);

			unique case (state_q)
				ST_RUN: begin
					if (acc && item_cmd == CMD_REPORT) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + sym_t'(1);
					if (scan_idx_q == SCAN_LAST) begin
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (sum_done) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1 <= item_cmd;
			sym_s1 <= item.symbol;
		end
		scan_first_s1 <= (scan_idx_q == '0);
		if (scan_vld_s1) begin
			if (scan_first_s1 || rd_data < min_q) begin
				min_q <= rd_data;
			end
			if (scan_first_s1 || rd_data > max_q) begin
				max_q <= rd_data;
			end
		end
	end

	assign result.valid       = out_vld_q;
	assign result.result_kind = out_kind_q;
	assign result.bin_count   = out_bin_q;
	assign result.min_count   = out_min_q;
	assign result.max_count   = out_max_q;

	`BHMM_ASSERT(a_count_never_wraps, clk, arst_n, wr.en |-> (wr.data != '0))
	`BHMM_ASSERT(a_read_reaches_output, clk, arst_n, rd_done |=> (result.valid && !result.result_kind))
	`BHMM_ASSERT(a_scan_ends, clk, arst_n, (state_q == ST_SCAN && scan_idx_q == SCAN_LAST) |=> (state_q == ST_REPORT))
	`BHMM_NEVER(a_min_above_max, clk, arst_n, state_q == ST_REPORT && !scan_vld_s1 && min_q > max_q)

endmodule
